@@ sv/rrp_pkg.sv @@
// ----------------------------------------------------------------------------
// RISC-V relocation patcher package
// Relocation kind codes, status codes and shared types.
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam logic [4:0] K_NONE    = 5'd0;
  localparam logic [4:0] K_BRANCH  = 5'd1;
  localparam logic [4:0] K_JAL     = 5'd2;
  localparam logic [4:0] K_CALL    = 5'd3;
  localparam logic [4:0] K_PCREL_HI = 5'd4;
  localparam logic [4:0] K_GOT_HI  = 5'd5;
  localparam logic [4:0] K_LO12_I  = 5'd6;
  localparam logic [4:0] K_LO12_S  = 5'd7;
  localparam logic [4:0] K_CBRANCH = 5'd8;
  localparam logic [4:0] K_CJUMP   = 5'd9;
  localparam logic [4:0] K_ADD32   = 5'd10;
  localparam logic [4:0] K_SUB32   = 5'd11;
  localparam logic [4:0] K_ADD16   = 5'd12;
  localparam logic [4:0] K_SUB16   = 5'd13;
  localparam logic [4:0] K_SUB8    = 5'd14;
  localparam logic [4:0] K_SET6    = 5'd15;
  localparam logic [4:0] K_SET8    = 5'd16;
  localparam logic [4:0] K_SET16   = 5'd17;
  localparam logic [4:0] K_SUB6    = 5'd18;
  localparam logic [4:0] K_PCREL32 = 5'd19;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_NO_HI   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // Lookup result handed from the table to the patch logic.
  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } lookup_t;

endpackage

@@ sv/rrp_hi_table.sv @@
// ----------------------------------------------------------------------------
// Hi20 pair table
// Holds place/value pairs in one synchronous memory. Records a pair on
// request; a lookup scans entries newest first, one read and compare each.
// ----------------------------------------------------------------------------
module rrp_hi_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec,
  input  logic [31:0]         rec_place,
  input  logic [31:0]         rec_value,
  output logic                full,
  input  logic                find,
  input  logic [31:0]         find_place,
  output logic                done,
  output rrp_pkg::lookup_t    result
);
  import rrp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [2:0] state;
  logic [31:0] key;

  assign full = (count == CW'(DEPTH));

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (rec && !full) begin
      mem[count[AW-1:0]] <= {rec_place, rec_value};
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (rec && !full) begin
      count <= count + CW'(1);
    end
  end

  // Newest-first scan: issue a read, compare the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      result <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (find) begin
            key <= find_place;
            result <= '0;
            if (count == '0) begin
              state <= S_DONE;
            end else begin
              idx <= count - CW'(1);
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (rd_data[63:32] == key) begin
            result.hit <= 1'b1;
            result.value <= rd_data[31:0];
            state <= S_DONE;
          end else if (idx == '0) begin
            state <= S_DONE;
          end else begin
            idx <= idx - CW'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign done = (state == S_DONE);

endmodule

@@ sv/rrp_patch.sv @@
// ----------------------------------------------------------------------------
// Relocation patch logic
// Computes the patched words and status for one relocation word.
// ----------------------------------------------------------------------------
module rrp_patch (
  input  logic [4:0]        req_type,
  input  logic [31:0]       site_word,
  input  logic [31:0]       site_word_next,
  input  logic [31:0]       place_addr,
  input  logic [31:0]       target_value,
  input  logic              table_full,
  input  rrp_pkg::lookup_t  lookup,
  output logic [31:0]       patched_word,
  output logic [31:0]       patched_word_next,
  output logic [2:0]        status
);
  import rrp_pkg::*;

  logic [31:0] off, t, w, wn, lo_off, diff, sum, hi;
  logic [15:0] h;
  logic [2:0]  st;

  always_comb begin
    off = target_value - place_addr;
    t = off >> 1;
    w = site_word;
    wn = site_word_next;
    st = ST_OK;
    h = '0;
    diff = site_word - target_value;
    sum = site_word + target_value;
    hi = (off + 32'h800) & 32'hfffff000;
    lo_off = lookup.hit ? (lookup.value - target_value) : 32'd0;
    case (req_type)
      K_NONE: begin
      end
      K_BRANCH: begin
        if (((off + 32'h1000) & ~32'h1ffe) != 32'd0) st = ST_RANGE;
        w = (site_word & ~32'hfe000f80) | ((t & 32'h800) << 20)
            | ((t & 32'h3f0) << 21) | ((t & 32'h00f) << 8) | ((t & 32'h400) >> 3);
      end
      K_JAL: begin
        if (((off + 32'h200000) & ~32'h3ffffe) != 32'd0) st = ST_RANGE;
        w = (site_word & 32'hfff) | {off[20], off[10:1], off[11], off[19:12], 12'd0};
      end
      K_CALL: begin
        w = (site_word & 32'hfff) | hi;
        wn = {off[11:0], site_word_next[19:0]};
      end
      K_PCREL_HI, K_GOT_HI: begin
        w = (site_word & 32'hfff) | hi;
        if (table_full) st = ST_FULL;
      end
      K_LO12_I: begin
        if (!lookup.hit) st = ST_NO_HI;
        w = {lo_off[11:0], site_word[19:0]};
      end
      K_LO12_S: begin
        if (!lookup.hit) st = ST_NO_HI;
        w = (site_word & ~32'hfe000f80) | ((lo_off & 32'hfe0) << 20)
            | ((lo_off & 32'h1f) << 7);
      end
      K_CBRANCH: begin
        if (((off + 32'h100) & ~32'h1fe) != 32'd0) st = ST_RANGE;
        h = (site_word[15:0] & 16'he383) | {3'd0, off[8], off[4:3], 3'd0,
            off[7:6], off[2:1], off[5], 2'd0};
        w = {site_word[31:16], h};
      end
      K_CJUMP: begin
        if (((off + 32'h800) & ~32'hffe) != 32'd0) st = ST_RANGE;
        h = (site_word[15:0] & 16'he003) | {3'd0, off[11], off[4], off[9:8],
            off[10], off[6], off[7], off[3:1], off[5], 2'd0};
        w = {site_word[31:16], h};
      end
      K_ADD32:   w = sum;
      K_SUB32:   w = diff;
      K_ADD16:   w = {site_word[31:16], sum[15:0]};
      K_SUB16:   w = {site_word[31:16], diff[15:0]};
      K_SUB8:    w = {site_word[31:8], diff[7:0]};
      K_SET6:    w = {site_word[31:6], target_value[5:0]};
      K_SET8:    w = {site_word[31:8], target_value[7:0]};
      K_SET16:   w = {site_word[31:16], target_value[15:0]};
      K_SUB6:    w = {site_word[31:6], diff[5:0]};
      K_PCREL32: w = site_word + off;
      default:   st = ST_UNKNOWN;
    endcase
    patched_word = w;
    patched_word_next = wn;
    status = st;
  end

endmodule

@@ sv/riscv_relocation_patcher.sv @@
// Most kinds go straight to the patch step; a lo12 first scans the recorded
// hi pairs (newest first, one memory read and compare per entry). One word is
// in work at a time: the next word is taken the cycle after the result leaves.
// Reset clears the pair count and control; the pair memory is not cleared.
// ----------------------------------------------------------------------------
// RISC-V relocation patcher
// Applies one RV32 relocation to a site word, keeping hi20 pairs in a table.
// ----------------------------------------------------------------------------
module riscv_relocation_patcher #(
  parameter int HI_TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  req_type,
  input  logic [31:0] site_word,
  input  logic [31:0] site_word_next,
  input  logic [31:0] place_addr,
  input  logic [31:0] target_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] patched_word,
  output logic [31:0] patched_word_next,
  output logic [2:0]  status
);
  import rrp_pkg::*;

  localparam int AW = (HI_TABLE_DEPTH > 1) ? $clog2(HI_TABLE_DEPTH) : 1;
  localparam int CW = $clog2(HI_TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state;
  logic [4:0]  r_type;
  logic [31:0] r_word, r_next, r_place, r_value;
  logic        full, rec, find, done;
  lookup_t     lk, lk_use;
  logic [31:0] p_word, p_next;
  logic [2:0]  p_st;
  logic        is_lo, is_hi, accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign is_lo = (r_type == K_LO12_I) || (r_type == K_LO12_S);
  assign is_hi = (r_type == K_PCREL_HI) || (r_type == K_GOT_HI);
  assign find = (state == S_LOOK);
  assign rec = (state == S_EXEC) && is_hi;
  assign lk_use = is_lo ? lk : '0;

  rrp_hi_table #(.DEPTH(HI_TABLE_DEPTH), .AW(AW), .CW(CW)) u_table (
    .clk(clk), .rst(rst), .rec(rec), .rec_place(r_place), .rec_value(r_value),
    .full(full), .find(find), .find_place(r_value), .done(done), .result(lk)
  );

  rrp_patch u_patch (
    .req_type(r_type), .site_word(r_word), .site_word_next(r_next),
    .place_addr(r_place), .target_value(r_value), .table_full(full),
    .lookup(lk_use), .patched_word(p_word), .patched_word_next(p_next),
    .status(p_st)
  );

  // Input capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_type <= req_type;
      r_word <= site_word;
      r_next <= site_word_next;
      r_place <= place_addr;
      r_value <= target_value;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= ((req_type == K_LO12_I) || (req_type == K_LO12_S)) ? S_LOOK : S_EXEC;
          end
        end
        S_LOOK: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (!is_lo || done) begin
            patched_word <= p_word;
            patched_word_next <= p_next;
            status <= p_st;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("result valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !accept)
    else $error("word accepted while busy");
  a_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(patched_word)))
    else $error("stalled result changed");
`endif

endmodule

@@ test/tb_riscv_relocation_patcher.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RISC-V relocation patcher testbench
// Drives relocation words through the patcher under several idle and stall
// patterns. It predicts every result with its own model of the hi20 pair
// table and the field scatter logic, and checks each output word in order.
// ----------------------------------------------------------------------------
module tb_riscv_relocation_patcher;
  import rrp_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [4:0] K_UNKNOWN_HIGH = 5'd31;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  req_type;
  logic [31:0] site_word;
  logic [31:0] site_word_next;
  logic [31:0] place_addr;
  logic [31:0] target_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] patched_word;
  logic [31:0] patched_word_next;
  logic [2:0]  status;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] word_next;
    logic [2:0]  st;
  } patch_result_t;

  // Predictor copy of the hi20 pair table.
  logic [31:0] pair_place [DEPTH];
  logic [31:0] pair_value [DEPTH];
  int          pair_count;

  patch_result_t expected_patches[$];
  int mismatch_count;
  int checked_count;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  int sent_count;

  riscv_relocation_patcher #(.HI_TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .site_word(site_word), .site_word_next(site_word_next),
    .place_addr(place_addr), .target_value(target_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .patched_word(patched_word), .patched_word_next(patched_word_next),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the patched words for one relocation and update the pair table.
  function automatic patch_result_t predict_patch(logic [4:0] kind, logic [31:0] w_in,
      logic [31:0] wn_in, logic [31:0] addr, logic [31:0] val);
    patch_result_t r;
    logic [31:0] w;
    logic [31:0] wn;
    logic [31:0] off;
    logic [31:0] t;
    logic [31:0] h;
    logic        hit;
    w = w_in;
    wn = wn_in;
    off = val - addr;
    r.st = ST_OK;
    hit = 1'b0;
    t = '0;
    case (kind)
      K_NONE: begin
      end
      K_BRANCH: begin
        if (((off + 32'h1000) & ~32'h1ffe) != 0) r.st = ST_RANGE;
        t = off >> 1;
        w = (w & ~32'hfe000f80) | ((t & 32'h800) << 20) | ((t & 32'h3f0) << 21)
            | ((t & 32'h00f) << 8) | ((t & 32'h400) >> 3);
      end
      K_JAL: begin
        if (((off + 32'h200000) & ~32'h3ffffe) != 0) r.st = ST_RANGE;
        w = (w & 32'hfff) | (((off >> 12) & 32'hff) << 12)
            | (((off >> 11) & 1) << 20) | (((off >> 1) & 32'h3ff) << 21)
            | (((off >> 20) & 1) << 31);
      end
      K_CALL: begin
        w = (w & 32'hfff) | ((off + 32'h800) & 32'hfffff000);
        wn = (wn & 32'hfffff) | ((off & 32'hfff) << 20);
      end
      K_PCREL_HI, K_GOT_HI: begin
        w = (w & 32'hfff) | ((off + 32'h800) & 32'hfffff000);
        if (pair_count < DEPTH) begin
          pair_place[pair_count] = addr;
          pair_value[pair_count] = val;
          pair_count++;
        end else begin
          r.st = ST_FULL;
        end
      end
      K_LO12_I, K_LO12_S: begin
        for (int i = pair_count - 1; i >= 0 && !hit; i--) begin
          if (pair_place[i] == val) begin
            hit = 1'b1;
            t = pair_value[i];
          end
        end
        if (hit) begin
          off = t - val;
        end else begin
          off = '0;
          r.st = ST_NO_HI;
        end
        if (kind == K_LO12_I) w = (w & 32'hfffff) | ((off & 32'hfff) << 20);
        else w = (w & ~32'hfe000f80) | ((off & 32'hfe0) << 20) | ((off & 32'h1f) << 7);
      end
      K_CBRANCH: begin
        if (((off + 32'h100) & ~32'h1fe) != 0) r.st = ST_RANGE;
        h = (w & 32'he383) | (((off >> 5) & 1) << 2) | (((off >> 1) & 3) << 3)
            | (((off >> 6) & 3) << 5) | (((off >> 3) & 3) << 10)
            | (((off >> 8) & 1) << 12);
        w = {w[31:16], h[15:0]};
      end
      K_CJUMP: begin
        if (((off + 32'h800) & ~32'hffe) != 0) r.st = ST_RANGE;
        h = (w & 32'he003) | (((off >> 5) & 1) << 2) | (((off >> 1) & 7) << 3)
            | (((off >> 7) & 1) << 6) | (((off >> 6) & 1) << 7)
            | (((off >> 10) & 1) << 8) | (((off >> 8) & 3) << 9)
            | (((off >> 4) & 1) << 11) | (((off >> 11) & 1) << 12);
        w = {w[31:16], h[15:0]};
      end
      K_ADD32: w = w + val;
      K_SUB32: w = w - val;
      K_ADD16: begin
        h = w + val;
        w = {w[31:16], h[15:0]};
      end
      K_SUB16: begin
        h = w - val;
        w = {w[31:16], h[15:0]};
      end
      K_SUB8: begin
        h = w - val;
        w = {w[31:8], h[7:0]};
      end
      K_SET6: w = {w[31:6], val[5:0]};
      K_SET8: w = {w[31:8], val[7:0]};
      K_SET16: w = {w[31:16], val[15:0]};
      K_SUB6: begin
        h = w - val;
        w = {w[31:6], h[5:0]};
      end
      K_PCREL32: w = w + off;
      default: r.st = ST_UNKNOWN;
    endcase
    r.word = w;
    r.word_next = wn;
    return r;
  endfunction

  // Send one word, predicting its result when it is accepted. Valid stays high
  // after the accepting edge; the next word or an idle cycle replaces it there.
  task automatic send_reloc(logic [4:0] kind, logic [31:0] w, logic [31:0] wn,
      logic [31:0] addr, logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    site_word <= w;
    site_word_next <= wn;
    place_addr <= addr;
    target_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_patches.push_back(predict_patch(kind, w, wn, addr, val));
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_patches.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);
  endtask

  // Random offset: mostly near the place so range checks sit close to the edge.
  function automatic logic [31:0] near_value(logic [31:0] addr);
    case ($urandom_range(3))
      0: return $urandom;
      1: return addr + ($urandom_range(8191) - 4096);
      2: return addr + ($urandom_range(511) - 256);
      default: return addr + ($urandom_range(32'h3fffff) - 32'h200000);
    endcase
  endfunction

  // Result checker: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    patch_result_t want;
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
    if (!rst) begin
      if (out_valid && !out_stall) begin
        checked_count++;
        if (expected_patches.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result word %h", patched_word);
        end else begin
          want = expected_patches.pop_front();
          if (want.word !== patched_word || want.word_next !== patched_word_next
              || want.st !== status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected %h %h st %0d, got %h %h st %0d",
                       want.word, want.word_next, want.st,
                       patched_word, patched_word_next, status);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Directed: extremes, every kind, range faults, missing hi, unknown kinds.
  task automatic test_directed();
    logic [4:0] k;
    for (int i = 0; i < 22; i++) begin
      k = 5'(i);
      send_reloc(k, 32'hffffffff, 32'h0, 32'h1000, 32'h1000 + 4 * i);
    end
    send_reloc(K_BRANCH, 32'h0, 32'hffffffff, 32'h0, 32'h1000);
    send_reloc(K_JAL, 32'h0, 32'h0, 32'h0, 32'hffffffff);
    send_reloc(K_CJUMP, 32'h0, 32'h0, 32'hffffffff, 32'h7fe);
    send_reloc(K_UNKNOWN_HIGH, 32'h12345678, 32'h9abcdef0, 32'h0, 32'h0);
  endtask

  // Fill the pair table past its depth, then look pairs up.
  task automatic test_table_full();
    for (int i = 0; i < DEPTH + 3; i++)
      send_reloc(K_PCREL_HI, $urandom, 0, 32'h100 + 4 * i, $urandom);
    for (int i = 0; i < 8; i++)
      send_reloc(i[0] ? K_LO12_S : K_LO12_I, $urandom, $urandom, $urandom,
                 32'h100 + 4 * $urandom_range(DEPTH + 2));
  endtask

  // Random: hi/lo pairs with random content, plus every other kind as noise.
  task automatic test_random(int n);
    logic [31:0] addr;
    logic [4:0]  k;
    for (int i = 0; i < n; i++) begin
      addr = $urandom;
      if (pair_count < DEPTH && $urandom_range(3) == 0) begin
        send_reloc($urandom_range(1) ? K_PCREL_HI : K_GOT_HI, $urandom, $urandom,
                   addr, $urandom);
        send_reloc($urandom_range(1) ? K_LO12_I : K_LO12_S, $urandom, $urandom,
                   $urandom, $urandom_range(3) == 0 ? $urandom : addr);
        i++;
      end else begin
        k = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(19));
        if ((k == K_LO12_I || k == K_LO12_S) && pair_count > 0 && $urandom_range(1))
          send_reloc(k, $urandom, $urandom, $urandom,
                     pair_place[$urandom_range(pair_count - 1)]);
        else send_reloc(k, $urandom, $urandom, addr, near_value(addr));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = '0;
    site_word = '0;
    site_word_next = '0;
    place_addr = '0;
    target_value = '0;
    pair_count = 0;
    sent_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(400);
    // Let every pending result drain before sending more.
    wait_drained();
    idle_pct = 45;
    test_random(400);
    idle_pct = 0;
    stall_pct = 45;
    test_random(400);
    idle_pct = 18;
    stall_pct = 18;
    test_random(400);
    test_table_full();
    idle_pct = 0;
    stall_pct = 0;
    test_random(400);
    wait_drained();

    $display("Covered %0d relocations of every kind, %0d results checked,", sent_count,
             checked_count);
    $display("with hi/lo pairing, a full pair table and varied idle/stall patterns.");
    if (mismatch_count == 0 && expected_patches.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
